// ----- rtl/core/ifct_pkg.sv -----
// ----------------------------------------------------------------------------
// ifct_pkg
// shared types, constants and helpers of the ipv4 flow counter table
// ----------------------------------------------------------------------------
package ifct_pkg;

    // table geometry
    localparam int FLOW_ENTRIES = 64;
    localparam int POS_W        = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
    localparam int USED_W       = $clog2(FLOW_ENTRIES + 1);
    localparam int GROUP_SIZE   = 8;
    localparam int GROUPS       = (FLOW_ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int CMP_W        = (USED_W > 6) ? USED_W : 6;

    // header constants
    localparam logic [15:0] ETYPE_IPV4    = 16'h0800;
    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [7:0]  PROTO_ZERO    = 8'd0;
    localparam logic [15:0] MIN_IP_BYTES  = 16'd20;
    localparam logic [15:0] MIN_TCP_BYTES = 16'd20;
    localparam logic [3:0]  MIN_TCP_WORDS = 4'd5;
    localparam logic [31:0] SAT32         = 32'hFFFF_FFFF;

    // operations
    localparam logic OP_CLASSIFY = 1'b0;
    localparam logic OP_READ     = 1'b1;

    // result status codes
    localparam logic [2:0] ST_COUNTED  = 3'd0;
    localparam logic [2:0] ST_NEW      = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_READ_OK  = 3'd3;
    localparam logic [2:0] ST_READ_OOR = 3'd4;

    typedef struct packed {
        logic        operation;
        logic [15:0] ethertype;
        logic [15:0] frame_len;
        logic [3:0]  header_words;
        logic [15:0] total_len;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [13:0] frag_bits;
        logic [7:0]  protocol;
        logic [3:0]  tcp_data_offset;
        logic [15:0] src_port;
        logic [5:0]  read_index;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  entry_position;
        logic [31:0] entry_count;
        logic [15:0] key_ethertype;
        logic [31:0] key_src_addr;
        logic [7:0]  key_protocol;
        logic [15:0] key_src_port;
        logic [31:0] total_packets;
    } out_item_t;

    typedef struct packed {
        logic [15:0] ethertype;
        logic [31:0] src_addr;
        logic [7:0]  protocol;
        logic [15:0] src_port;
    } key_t;

    typedef struct packed {
        key_t        key;
        logic [31:0] count;
    } entry_t;

    // one cell's contribution to the match reduction
    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] pos;
        entry_t           entry;
    } found_t;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        key_t              key;
        logic              read_op;
        logic              read_ok;
        logic [USED_W-1:0] read_sel;
        logic [USED_W-1:0] used;
        logic              shift_en;
        logic              inc_en;
    } cell_ctrl_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == SAT32) ? v : v + 32'd1;
    endfunction

endpackage

// ----- rtl/core/ipv4_flow_counter_table.sv -----
// ----------------------------------------------------------------------------
// ipv4_flow_counter_table
// classifies packet headers into flows and counts them in a cell chain
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            payload
//   in        input      in_valid / in_ready  in_data  (in_item_t)
//   out       output     out_valid/out_ready  out_data (out_item_t)
//
// each transaction passes through capture, key build, cell compare with
// group reduction, final reduction with table update; the compare and update
// run across all cells of the chain at once, so the number of steps does not
// grow with the table size
// a new entry is pushed into cell 0 and every other cell takes its neighbor's
// contents, so cell j always holds newest-first position j
// reset clears the fill count, packet total and handshake state; entry
// contents are not cleared and cells beyond the fill count never match
// the input is taken again as soon as the sequencer is idle, even while a
// result waits in the output register; a second result waits in the final
// step until the output register is free
//
module ipv4_flow_counter_table
    import ifct_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_KEY   = 2'd1;
    localparam logic [1:0] S_MATCH = 2'd2;
    localparam logic [1:0] S_FINAL = 2'd3;

    logic [1:0]        state_reg, state_next;
    in_item_t          item_reg;
    key_t              key_reg;
    key_t              key_comb;
    logic [USED_W-1:0] used_reg, used_next;
    logic [31:0]       seen_reg, seen_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_reg, out_next;

    cell_ctrl_t        ctrl;
    entry_t            new_entry;
    entry_t            cell_entry [FLOW_ENTRIES];
    found_t            cell_found [GROUPS*GROUP_SIZE];
    found_t            group_comb [GROUPS];
    found_t            group_reg  [GROUPS];
    found_t            any_found;
    logic              final_go;
    logic              table_full;

    ifct_classify u_classify
    (
        .item (item_reg),
        .key  (key_comb)
    );

    // final step may commit only when the output slot is free
    assign final_go   = (state_reg == S_FINAL) && (!out_valid_reg || out_ready);
    assign table_full = (used_reg == USED_W'(FLOW_ENTRIES));

    always_comb
    begin
        ctrl.key      = key_reg;
        ctrl.read_op  = (item_reg.operation == OP_READ);
        ctrl.read_ok  = CMP_W'(item_reg.read_index) < CMP_W'(used_reg);
        ctrl.read_sel = USED_W'(item_reg.read_index);
        ctrl.used     = used_reg;
        ctrl.inc_en   = final_go && (item_reg.operation == OP_CLASSIFY) && any_found.hit;
        ctrl.shift_en = final_go && (item_reg.operation == OP_CLASSIFY) && !any_found.hit &&
                        !table_full;
    end

    assign new_entry.key   = key_reg;
    assign new_entry.count = 32'd1;

    // chain of cells, cell 0 is the newest entry
    genvar j;
    generate
        for (j = 0; j < GROUPS*GROUP_SIZE; j++)
        begin : g_cell
            if (j < FLOW_ENTRIES)
            begin : g_real
                ifct_cell u_cell
                (
                    .clk        (clk),
                    .pos        (POS_W'(j)),
                    .ctrl       (ctrl),
                    .prev_entry ((j == 0) ? new_entry : cell_entry[(j == 0) ? 0 : j-1]),
                    .entry      (cell_entry[j]),
                    .found      (cell_found[j])
                );
            end
            else
            begin : g_pad
                assign cell_found[j] = '0;
            end
        end
    endgenerate

    // first reduction level: or of one-hot matches within a group, registered
    genvar g;
    generate
        for (g = 0; g < GROUPS; g++)
        begin : g_group
            always_comb
            begin
                group_comb[g] = '0;
                for (int k = 0; k < GROUP_SIZE; k++)
                begin
                    group_comb[g] = group_comb[g] | cell_found[g*GROUP_SIZE + k];
                end
            end

            always_ff @(posedge clk)
            begin
                group_reg[g] <= group_comb[g];
            end
        end
    endgenerate

    // second reduction level
    always_comb
    begin
        any_found = '0;
        for (int k = 0; k < GROUPS; k++)
        begin
            any_found = any_found | group_reg[k];
        end
    end

    // result and next state
    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        seen_next      = seen_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_KEY;
            end
            S_KEY:
            begin
                state_next = S_MATCH;
            end
            S_MATCH:
            begin
                state_next = S_FINAL;
            end
            S_FINAL:
            begin
                if (final_go)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    if (item_reg.operation == OP_READ)
                    begin
                        out_next.total_packets = seen_reg;
                        if (any_found.hit)
                        begin
                            out_next.status         = ST_READ_OK;
                            out_next.entry_position = 6'(any_found.pos);
                            out_next.entry_count    = any_found.entry.count;
                            out_next.key_ethertype  = any_found.entry.key.ethertype;
                            out_next.key_src_addr   = any_found.entry.key.src_addr;
                            out_next.key_protocol   = any_found.entry.key.protocol;
                            out_next.key_src_port   = any_found.entry.key.src_port;
                        end
                        else
                        begin
                            out_next.status = ST_READ_OOR;
                        end
                    end
                    else
                    begin
                        seen_next              = sat_inc(seen_reg);
                        out_next.total_packets = sat_inc(seen_reg);
                        out_next.key_ethertype = key_reg.ethertype;
                        out_next.key_src_addr  = key_reg.src_addr;
                        out_next.key_protocol  = key_reg.protocol;
                        out_next.key_src_port  = key_reg.src_port;
                        if (any_found.hit)
                        begin
                            out_next.status         = ST_COUNTED;
                            out_next.entry_position = 6'(any_found.pos);
                            out_next.entry_count    = sat_inc(any_found.entry.count);
                        end
                        else if (!table_full)
                        begin
                            out_next.status      = ST_NEW;
                            out_next.entry_count = 32'd1;
                            used_next            = used_reg + USED_W'(1);
                        end
                        else
                        begin
                            out_next.status = ST_FULL;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= in_data;
        if (state_reg == S_KEY)
            key_reg <= key_comb;
        out_reg <= out_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ----- rtl/core/ifct_classify.sv -----
// ----------------------------------------------------------------------------
// ifct_classify
// builds the flow key from one packet's header fields
// ----------------------------------------------------------------------------
module ifct_classify
    import ifct_pkg::*;
(
    input  in_item_t item,
    output key_t     key
);

    logic [15:0] hbytes;
    logic [15:0] rest;
    logic [15:0] tcp_bytes;
    logic        len_ok;
    logic        dst_stop;
    logic        tcp_ok;

    always_comb
    begin
        hbytes    = {10'd0, item.header_words, 2'b00};
        rest      = item.frame_len - hbytes;
        tcp_bytes = {10'd0, item.tcp_data_offset, 2'b00};
        len_ok    = (item.frame_len >= MIN_IP_BYTES) && (hbytes <= item.frame_len) &&
                    (item.total_len <= item.frame_len) && (item.total_len >= hbytes);
        // multicast, broadcast or fragment
        dst_stop  = (item.dst_addr[31:28] == 4'hE) || (item.dst_addr == SAT32) ||
                    (item.frag_bits != 14'd0);
        tcp_ok    = (rest >= MIN_TCP_BYTES) && (item.tcp_data_offset >= MIN_TCP_WORDS) &&
                    (rest >= tcp_bytes);

        key.ethertype = item.ethertype;
        key.src_addr  = '0;
        key.protocol  = '0;
        key.src_port  = '0;
        if (item.ethertype == ETYPE_IPV4 && len_ok)
        begin
            key.src_addr = item.src_addr;
            if (!dst_stop)
            begin
                key.protocol = item.protocol;
                if ((item.protocol == PROTO_TCP || item.protocol == PROTO_ZERO) && tcp_ok)
                begin
                    key.src_port = item.src_port;
                end
            end
        end
    end

endmodule

// ----- rtl/core/ifct_cell.sv -----
// ----------------------------------------------------------------------------
// ifct_cell
// one table entry: local compare, counter update, shift from neighbor
// ----------------------------------------------------------------------------
module ifct_cell
    import ifct_pkg::*;
(
    input  logic             clk,
    input  logic [POS_W-1:0] pos,
    input  cell_ctrl_t       ctrl,
    input  entry_t           prev_entry,
    output entry_t           entry,
    output found_t           found
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   occupied;
    logic   hit;

    always_comb
    begin
        // entries are kept newest first, so position below fill means occupied
        occupied = USED_W'(pos) < ctrl.used;
        if (ctrl.read_op)
            hit = occupied && ctrl.read_ok && (USED_W'(pos) == ctrl.read_sel);
        else
            hit = occupied && (entry_reg.key == ctrl.key);

        entry_next = entry_reg;
        if (ctrl.shift_en)
            entry_next = prev_entry;
        else if (ctrl.inc_en && hit)
            entry_next.count = sat_inc(entry_reg.count);

        found = '0;
        if (hit)
        begin
            found.hit   = 1'b1;
            found.pos   = pos;
            found.entry = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the ipv4 flow counter table: a local flow table
// predicts every result, which is checked in order against the block under
// random idling, long output back-pressure and a drained pause
// ----------------------------------------------------------------------------
module tb_top
    import ifct_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int POOL_SIZE    = 72;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_MAX   = 10;

    // clock, reset and the two channels, all known from time zero
    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    // local copy of the flow table, insertion order, slot 0 is oldest
    key_t        flow_key   [FLOW_ENTRIES];
    logic [31:0] flow_count [FLOW_ENTRIES];
    int unsigned flows_stored = 0;
    logic [31:0] packet_total = '0;

    // predicted results waiting for the block, oldest first
    out_item_t   pending_results[$];
    out_item_t   oldest_expected;

    // flow keys that random traffic keeps coming back to, so hits recur
    key_t        key_pool [POOL_SIZE];

    // idling controls shared by the sender, the receiver and the tests
    bit          sender_calm   = 1'b0;
    bit          receiver_calm = 1'b0;
    int          hold_left     = 0;

    int          mismatch_count = 0;
    int          cycle_count    = 0;

    ipv4_flow_counter_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // flow prediction
    // ------------------------------------------------------------------------

    // counters stick at all ones
    function automatic logic [31:0] bump(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    // works out the result of one accepted transaction and updates the table
    function automatic out_item_t predict_flow_result(input in_item_t it);
        out_item_t   r;
        key_t        k;
        int unsigned hbytes;
        int unsigned rest;
        int unsigned slot;
        int          found;
        r     = '0;
        k     = '0;
        found = -1;

        // read: newest first, anything past the fill count is out of range
        if (it.operation == OP_READ)
        begin
            if (it.read_index < flows_stored)
            begin
                slot             = flows_stored - 1 - it.read_index;
                r.status         = ST_READ_OK;
                r.entry_position = it.read_index;
                r.entry_count    = flow_count[slot];
                r.key_ethertype  = flow_key[slot].ethertype;
                r.key_src_addr   = flow_key[slot].src_addr;
                r.key_protocol   = flow_key[slot].protocol;
                r.key_src_port   = flow_key[slot].src_port;
            end
            else
                r.status = ST_READ_OOR;
            // read leaves the packet total untouched
            r.total_packets = packet_total;
            return r;
        end

        // key build: each stage only if the previous one was taken
        k.ethertype = it.ethertype;
        if (it.ethertype == ETYPE_IPV4)
        begin
            hbytes = it.header_words * 4;
            // header length below 5 words passes if the byte checks hold
            if (it.frame_len >= MIN_IP_BYTES && hbytes <= it.frame_len &&
                it.total_len <= it.frame_len && it.total_len >= hbytes)
            begin
                k.src_addr = it.src_addr;
                // multicast, broadcast and fragments stop after the address
                if (it.dst_addr[31:28] != 4'hE && it.dst_addr != 32'hFFFF_FFFF &&
                    it.frag_bits == '0)
                begin
                    k.protocol = it.protocol;
                    if (it.protocol == PROTO_TCP || it.protocol == PROTO_ZERO)
                    begin
                        rest = it.frame_len - hbytes;
                        // port only from a complete tcp header
                        if (rest >= MIN_TCP_BYTES &&
                            it.tcp_data_offset >= MIN_TCP_WORDS &&
                            rest >= it.tcp_data_offset * 4)
                            k.src_port = it.src_port;
                    end
                end
            end
        end

        packet_total = bump(packet_total);

        for (int i = 0; i < flows_stored; i++)
            if (found < 0 && flow_key[i] == k)
                found = i;

        if (found >= 0)
        begin
            flow_count[found] = bump(flow_count[found]);
            r.status          = ST_COUNTED;
            r.entry_position  = 6'(flows_stored - 1 - found);
            r.entry_count     = flow_count[found];
        end
        else if (flows_stored < FLOW_ENTRIES)
        begin
            flow_key[flows_stored]   = k;
            flow_count[flows_stored] = 32'd1;
            flows_stored             = flows_stored + 1;
            r.status                 = ST_NEW;
            r.entry_count            = 32'd1;
        end
        else
            // table full: key reported, nothing stored, packet still counted
            r.status = ST_FULL;

        r.key_ethertype = k.ethertype;
        r.key_src_addr  = k.src_addr;
        r.key_protocol  = k.protocol;
        r.key_src_port  = k.src_port;
        r.total_packets = packet_total;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // every field random, any operation
    function automatic in_item_t noise_item();
        in_item_t it;
        it.operation       = 1'($urandom_range(1));
        it.ethertype       = 16'($urandom);
        it.frame_len       = 16'($urandom);
        it.header_words    = 4'($urandom);
        it.total_len       = 16'($urandom);
        it.src_addr        = $urandom;
        it.dst_addr        = $urandom;
        it.frag_bits       = 14'($urandom);
        it.protocol        = 8'($urandom);
        it.tcp_data_offset = 4'($urandom);
        it.src_port        = 16'($urandom);
        it.read_index      = 6'($urandom);
        return it;
    endfunction

    // well-formed tcp over ipv4, every check passes
    function automatic in_item_t tcp_header();
        in_item_t it;
        it                 = '0;
        it.operation       = OP_CLASSIFY;
        it.ethertype       = ETYPE_IPV4;
        it.frame_len       = 16'd40;
        it.header_words    = 4'd5;
        it.total_len       = 16'd40;
        it.src_addr        = 32'h0A00_0001;
        it.dst_addr        = 32'h0A00_0002;
        it.protocol        = PROTO_TCP;
        it.tcp_data_offset = 4'd5;
        it.src_port        = 16'd80;
        return it;
    endfunction

    // mostly well-formed headers on pool keys, some reads, some broken ones
    function automatic in_item_t random_traffic_item();
        in_item_t    it;
        key_t        k;
        int unsigned pick;
        int unsigned hmax;
        int unsigned hbytes;
        int unsigned dmax;
        it   = noise_item();
        pick = $urandom_range(99);
        if (pick < 12)
        begin
            it.operation = OP_READ;
            return it;
        end

        k                  = key_pool[$urandom_range(POOL_SIZE - 1)];
        it.operation       = OP_CLASSIFY;
        it.ethertype       = k.ethertype;
        it.src_addr        = k.src_addr;
        it.protocol        = k.protocol;
        it.src_port        = k.src_port;
        it.frame_len       = ($urandom_range(9) == 0) ? 16'($urandom_range(40, 65535))
                                                      : 16'($urandom_range(40, 1500));
        hmax               = (it.frame_len - 20) / 4;
        if (hmax > 15)
            hmax = 15;
        it.header_words    = 4'($urandom_range(5, hmax));
        hbytes             = it.header_words * 4;
        it.total_len       = 16'($urandom_range(hbytes, it.frame_len));
        dmax               = (it.frame_len - hbytes) / 4;
        if (dmax > 15)
            dmax = 15;
        it.tcp_data_offset = 4'($urandom_range(5, dmax));
        it.frag_bits       = '0;
        if (it.dst_addr == 32'hFFFF_FFFF)
            it.dst_addr[0] = 1'b0;
        if (it.dst_addr[31:28] == 4'hE)
            it.dst_addr[31] = 1'b0;

        // broken headers: one check fails, or plain noise
        if (pick < 30)
            case ($urandom_range(5))
                0: it.dst_addr[31:28] = 4'hE;
                1: it.dst_addr        = 32'hFFFF_FFFF;
                2: it.frag_bits       = 14'($urandom_range(1, 16383));
                3: it.frame_len       = 16'($urandom_range(19));
                4: it.tcp_data_offset = 4'($urandom_range(4));
                default:
                begin
                    it           = noise_item();
                    it.operation = OP_CLASSIFY;
                    if ($urandom_range(1))
                        it.ethertype = ETYPE_IPV4;
                end
            endcase
        return it;
    endfunction

    // one transaction: optional gap, then hold valid until accepted
    task automatic send_item(input in_item_t it);
        int gap;
        gap = 0;
        if (!sender_calm && $urandom_range(99) < 8)
            gap = $urandom_range(1, 6);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(predict_flow_result(it));
    endtask

    // lower valid and let every predicted result come back
    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // field extremes, both operations and each classification corner
    task automatic test_directed();
        in_item_t it;

        // reads on an empty table
        it            = '0;
        it.operation  = OP_READ;
        send_item(it);
        it.read_index = 6'd63;
        send_item(it);

        // non-ipv4 frames key on the ethertype alone
        it            = '0;
        it.operation  = OP_CLASSIFY;
        send_item(it);
        it            = '1;
        it.operation  = OP_CLASSIFY;
        send_item(it);

        // complete tcp header, then the same flow again for a hit
        send_item(tcp_header());
        send_item(tcp_header());

        // largest fields with a complete tcp header
        it                 = tcp_header();
        it.src_addr        = 32'hFFFF_FFFF;
        it.src_port        = 16'hFFFF;
        it.frame_len       = 16'hFFFF;
        it.total_len       = 16'hFFFF;
        it.header_words    = 4'd15;
        it.tcp_data_offset = 4'd15;
        send_item(it);

        // inconsistent lengths fall back to the ethertype
        it              = tcp_header();
        it.frame_len    = 16'd19;
        it.total_len    = 16'd19;
        it.header_words = 4'd4;
        send_item(it);
        it              = tcp_header();
        it.header_words = 4'd15;
        send_item(it);
        it              = tcp_header();
        it.total_len    = 16'd41;
        send_item(it);
        it              = tcp_header();
        it.total_len    = 16'd16;
        send_item(it);

        // header word count of zero still passes the byte checks
        it              = tcp_header();
        it.header_words = 4'd0;
        it.frame_len    = 16'd20;
        it.total_len    = 16'd20;
        it.src_addr     = 32'h0A00_0003;
        send_item(it);

        // multicast, broadcast and fragments stop after the address
        it              = tcp_header();
        it.dst_addr     = 32'hE000_0000;
        send_item(it);
        it.dst_addr     = 32'hEFFF_FFFF;
        send_item(it);
        it.dst_addr     = 32'hFFFF_FFFF;
        send_item(it);
        it              = tcp_header();
        it.frag_bits    = 14'h2000;
        send_item(it);
        it.frag_bits    = 14'h1FFF;
        send_item(it);

        // protocol zero takes the port like tcp, udp does not
        it              = tcp_header();
        it.protocol     = PROTO_ZERO;
        send_item(it);
        it.protocol     = 8'd17;
        send_item(it);

        // incomplete tcp header: short rest, short offset, offset past rest
        it              = tcp_header();
        it.frame_len    = 16'd39;
        it.total_len    = 16'd39;
        send_item(it);
        it              = tcp_header();
        it.tcp_data_offset = 4'd4;
        send_item(it);
        it.tcp_data_offset = 4'd15;
        send_item(it);

        // newest, oldest and first unused entry
        it              = noise_item();
        it.operation    = OP_READ;
        it.read_index   = 6'd0;
        send_item(it);
        it.read_index   = 6'(flows_stored - 1);
        send_item(it);
        it.read_index   = 6'(flows_stored);
        send_item(it);
    endtask

    // random traffic over the key pool, fills the table and runs it full
    task automatic test_random_traffic(input int count);
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            key_pool[i].ethertype = ($urandom_range(9) < 7) ? ETYPE_IPV4 : 16'($urandom);
            key_pool[i].src_addr  = $urandom;
            case ($urandom_range(4))
                0, 1:    key_pool[i].protocol = PROTO_TCP;
                2:       key_pool[i].protocol = PROTO_ZERO;
                default: key_pool[i].protocol = 8'($urandom);
            endcase
            key_pool[i].src_port  = 16'($urandom);
        end
        for (int i = 0; i < count; i++)
            send_item(random_traffic_item());
    endtask

    // receiver holds off for a long stretch while the sender keeps offering
    task automatic test_output_backpressure(input int count);
        sender_calm = 1'b1;
        hold_left   = HOLD_CYCLES;
        for (int i = 0; i < count; i++)
            send_item(random_traffic_item());
        sender_calm = 1'b0;
    endtask

    // back-to-back transactions with no idling on either side
    task automatic test_full_rate(input int count);
        sender_calm   = 1'b1;
        receiver_calm = 1'b1;
        for (int i = 0; i < count; i++)
            send_item(random_traffic_item());
        sender_calm   = 1'b0;
        receiver_calm = 1'b0;
    endtask

    // sender stops until the block is empty, then carries on
    task automatic test_drained_pause(input int count);
        for (int i = 0; i < count; i++)
            send_item(random_traffic_item());
        wait_all_results();
        for (int i = 0; i < count; i++)
            send_item(random_traffic_item());
    endtask

    // ------------------------------------------------------------------------
    // receiver and result check
    // ------------------------------------------------------------------------

    // random ready, or held low while a hold-off is counting down
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= receiver_calm || ($urandom_range(99) >= 8);
    end

    task automatic log_mismatch(input string why, input out_item_t want,
                                input out_item_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
        begin
            $display("mismatch (%s) at cycle %0d", why, cycle_count);
            $display("  expected st=%0d pos=%0d cnt=%h key=%h/%h/%h/%h tot=%h",
                     want.status, want.entry_position, want.entry_count,
                     want.key_ethertype, want.key_src_addr, want.key_protocol,
                     want.key_src_port, want.total_packets);
            $display("  actual   st=%0d pos=%0d cnt=%h key=%h/%h/%h/%h tot=%h",
                     got.status, got.entry_position, got.entry_count,
                     got.key_ethertype, got.key_src_addr, got.key_protocol,
                     got.key_src_port, got.total_packets);
        end
    endtask

    // every accepted result against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                log_mismatch("no result expected", '0, out_data);
            else
            begin
                oldest_expected = pending_results.pop_front();
                if (out_data.status         !== oldest_expected.status         ||
                    out_data.entry_position !== oldest_expected.entry_position ||
                    out_data.entry_count    !== oldest_expected.entry_count    ||
                    out_data.key_ethertype  !== oldest_expected.key_ethertype  ||
                    out_data.key_src_addr   !== oldest_expected.key_src_addr   ||
                    out_data.key_protocol   !== oldest_expected.key_protocol   ||
                    out_data.key_src_port   !== oldest_expected.key_src_port   ||
                    out_data.total_packets  !== oldest_expected.total_packets)
                    log_mismatch("field differs", oldest_expected, out_data);
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_traffic(380);
        test_output_backpressure(40);
        test_full_rate(60);
        test_drained_pause(22);

        // last transaction sent, let the pipeline empty out
        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
